// ===== src/lhp_pkg.sv =====
// ----------------------------------------------------------------------------
// lhp_pkg
// shared types, constants and helpers for the latency histogram block
// ----------------------------------------------------------------------------
package lhp_pkg;

  localparam int unsigned Probes    = 8;
  localparam int unsigned Buckets   = 64;
  localparam int unsigned ProbeW    = 3;
  localparam int unsigned BucketW   = 6;
  localparam int unsigned CntW      = 48;
  localparam int unsigned DataW     = 64;
  localparam int unsigned RankW     = CntW + 7;
  localparam int unsigned CumW      = CntW + BucketW;
  localparam int unsigned CmpW      = CumW + 7;
  localparam int unsigned HistDepth = Probes * Buckets;
  localparam int unsigned HistAddrW = ProbeW + BucketW;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  localparam logic [1:0] KindRecord = 2'd0;
  localparam logic [1:0] KindQuery  = 2'd1;
  localparam logic [1:0] KindClear  = 2'd2;
  localparam logic [1:0] KindNone   = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ProbeW-1:0] probe_index;
    logic [DataW-1:0] elapsed_ns;
    logic [DataW-1:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic [ProbeW-1:0] probe_id;
    logic [CntW-1:0]   sample_count;
    logic [DataW-1:0]  time_total;
    logic [DataW-1:0]  time_min;
    logic [DataW-1:0]  time_max;
    logic [DataW-1:0]  bytes_sum;
    logic [DataW-1:0]  p50_ns;
    logic [DataW-1:0]  p95_ns;
    logic [DataW-1:0]  p99_ns;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the input item
    logic rec_rd;    // read the bucket entry
    logic rec_wr;    // write back record update
    logic clr_step;  // clear one bucket row entry
    logic walk_rd;   // issue bucket read for the walk
    logic walk_acc;  // accumulate returned bucket
    logic q_start;   // load query stats and ranks
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic walk_last;
    logic walk_done;
  } stat_t;

  // floor(log2(v)), 0 and 1 in bucket 0, clipped at the last bucket
  function automatic logic [BucketW-1:0] log_bucket(input logic [DataW-1:0] v);
    logic [BucketW-1:0] b;
    b = '0;
    for (int i = 1; i < DataW; i++) begin
      if (v[i]) b = BucketW'(i);
    end
    return b;
  endfunction

  function automatic logic [DataW-1:0] bucket_bound(input logic [BucketW-1:0] b);
    logic [DataW:0] one;
    one = '0;
    if (b == BucketW'(Buckets - 1)) return {DataW{1'b1}};
    one[b + 1] = 1'b1;
    return DataW'(one - 1'b1);
  endfunction

endpackage

// ===== src/latency_histogram_percentiles.sv =====
// ----------------------------------------------------------------------------
// latency_histogram_percentiles
// per-probe latency monitor with log2 histogram and percentile bounds
// ----------------------------------------------------------------------------
// record: read and write of the bucket entry in separate states; clear: one
//   bucket entry a cycle; query: bucket walk, skipped on an empty probe
// one item at a time; a query result is held until the output takes it, and
//   the registered-read bucket memory makes a record a read-modify-write
// reset: counts and sums cleared at once, then a sweep zeroes all 512 bucket
//   entries with the input stalled; min and max undefined until written
module latency_histogram_percentiles
  import lhp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  lhp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (in_item_i.kind),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // storage and arithmetic
  lhp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule

// ===== src/lhp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lhp_ctrl
// sequencer for record, query walk and clear sweep
// ----------------------------------------------------------------------------
module lhp_ctrl
  import lhp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  logic [1:0] kind_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output cmd_t  cmd_o,
  input  stat_t stat_i
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRecRd = 7'b0000010,
    StRecWr = 7'b0000100,
    StClr   = 7'b0001000,
    StQLoad = 7'b0010000,
    StWalk  = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   walk_pend_q, walk_pend_d;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d     = state_q;
    walk_pend_d = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          priority if (kind_i == KindRecord) state_d = StRecRd;
          else if (kind_i == KindQuery) state_d = StQLoad;
          else if (kind_i == KindClear) state_d = StClr;
          else state_d = StIdle;
        end
      end
      StRecRd: begin
        cmd_o.rec_rd = 1'b1;
        state_d = StRecWr;
      end
      StRecWr: begin
        cmd_o.rec_wr = 1'b1;
        state_d = StIdle;
      end
      StClr: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) state_d = StIdle;
      end
      StQLoad: begin
        cmd_o.q_start = 1'b1;
        state_d = StWalk;
      end
      StWalk: begin
        cmd_o.walk_acc = walk_pend_q;
        if (stat_i.walk_done) begin
          state_d = StOut;
        end else begin
          cmd_o.walk_rd = !stat_i.walk_last;
          walk_pend_d = 1'b1;
        end
      end
      StOut: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // reset starts with a sweep that zeroes the bucket memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClr;
      walk_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      walk_pend_q <= walk_pend_d;
    end
  end

endmodule

// ===== src/lhp_dp.sv =====
// ----------------------------------------------------------------------------
// lhp_dp
// probe statistics, bucket memory and percentile walk
// ----------------------------------------------------------------------------
module lhp_dp
  import lhp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  cmd_t      cmd_i,
  output stat_t     stat_o,
  output out_item_t out_item_o
);

  logic [CntW-1:0]  cnt_q   [Probes];
  logic [DataW-1:0] tsum_q  [Probes];
  logic [DataW-1:0] bsum_q  [Probes];
  logic [DataW-1:0] tmin_q  [Probes];
  logic [DataW-1:0] tmax_q  [Probes];

  logic [CntW-1:0]  hist_mem [HistDepth];
  logic [CntW-1:0]  hist_rd_q;
  logic [HistAddrW-1:0] hist_rd_addr, hist_wr_addr;
  logic             hist_rd_en, hist_wr_en;
  logic [CntW-1:0]  hist_wr_data;

  in_item_t         item_q;
  logic [BucketW-1:0] bkt_q;
  logic [HistAddrW:0] clr_q;
  logic [BucketW:0]   walk_rd_q;
  logic [BucketW-1:0] walk_b_q;
  logic [CumW-1:0]    cum_q;
  logic [RankW-1:0]   rank_q [3];
  logic [1:0]         t_q;
  out_item_t          res_q;
  logic               first_q;

  logic [CntW-1:0] hist_inc;
  logic [CumW-1:0] cum_next;
  logic [CmpW-1:0] cum_x100;
  logic [1:0]      t_next;
  logic [DataW-1:0] p_next [3];
  logic [CntW-1:0] qcnt;

  assign hist_inc = (hist_rd_q == CntMax) ? CntMax : hist_rd_q + 1'b1;
  assign qcnt     = cnt_q[item_q.probe_index];

  always_comb begin
    hist_rd_en   = cmd_i.rec_rd || cmd_i.walk_rd;
    hist_rd_addr = cmd_i.rec_rd ? {item_q.probe_index, bkt_q}
                                : {item_q.probe_index, walk_rd_q[BucketW-1:0]};
    hist_wr_en   = cmd_i.rec_wr || cmd_i.clr_step;
    hist_wr_addr = cmd_i.clr_step ? clr_q[HistAddrW-1:0]
                                  : {item_q.probe_index, bkt_q};
    hist_wr_data = cmd_i.clr_step ? '0 : hist_inc;
  end

  always_ff @(posedge clk_i) begin
    if (hist_wr_en) hist_mem[hist_wr_addr] <= hist_wr_data;
    if (hist_rd_en) hist_rd_q <= hist_mem[hist_rd_addr];
  end

  // percentile step: several ranks may be crossed by one bucket
  // cum > floor(cnt*P/100) holds exactly when 100*cum > cnt*P
  always_comb begin
    cum_next = cum_q + CumW'(hist_rd_q);
    cum_x100 = (CmpW'(cum_next) << 6) + (CmpW'(cum_next) << 5) + (CmpW'(cum_next) << 2);
    t_next   = t_q;
    for (int j = 0; j < 3; j++) p_next[j] = '0;
    p_next[0] = res_q.p50_ns;
    p_next[1] = res_q.p95_ns;
    p_next[2] = res_q.p99_ns;
    for (int j = 0; j < 3; j++) begin
      if (t_next == 2'(j) && cum_x100 > CmpW'(rank_q[j])) begin
        p_next[j] = bucket_bound(walk_b_q);
        t_next    = t_next + 1'b1;
      end
    end
  end

  assign stat_o.clr_done  = (clr_q == (HistAddrW+1)'(HistDepth - 1));
  assign stat_o.walk_last = (walk_rd_q == (BucketW+1)'(Buckets));
  assign stat_o.walk_done = (t_q == 2'd3) || first_q;
  assign out_item_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Probes; i++) begin
        cnt_q[i]  <= '0;
        tsum_q[i] <= '0;
        bsum_q[i] <= '0;
      end
      clr_q   <= '0;
      t_q     <= '0;
      first_q <= 1'b0;
    end else begin
      if (cmd_i.capture) clr_q <= '0;
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
        for (int i = 0; i < Probes; i++) begin
          cnt_q[i]  <= '0;
          tsum_q[i] <= '0;
          bsum_q[i] <= '0;
        end
      end
      if (cmd_i.rec_wr) begin
        cnt_q[item_q.probe_index]  <= (qcnt == CntMax) ? CntMax : qcnt + 1'b1;
        tsum_q[item_q.probe_index] <= tsum_q[item_q.probe_index] + item_q.elapsed_ns;
        bsum_q[item_q.probe_index] <= bsum_q[item_q.probe_index] + item_q.byte_count;
      end
      if (cmd_i.q_start) begin
        t_q     <= '0;
        first_q <= (qcnt == '0);
      end
      // stop after the last bucket even if a rank was never crossed
      if (cmd_i.walk_acc)
        t_q <= (walk_b_q == BucketW'(Buckets - 1)) ? 2'd3 : t_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
      bkt_q  <= log_bucket(in_item_i.elapsed_ns);
    end
    if (cmd_i.rec_wr) begin
      if (qcnt == '0 || item_q.elapsed_ns < tmin_q[item_q.probe_index])
        tmin_q[item_q.probe_index] <= item_q.elapsed_ns;
      if (qcnt == '0 || item_q.elapsed_ns > tmax_q[item_q.probe_index])
        tmax_q[item_q.probe_index] <= item_q.elapsed_ns;
    end
    if (cmd_i.q_start) begin
      res_q.probe_id <= item_q.probe_index;
      if (qcnt == '0) begin
        res_q.sample_count <= '0;
        res_q.time_total   <= '0;
        res_q.time_min     <= '0;
        res_q.time_max     <= '0;
        res_q.bytes_sum    <= '0;
        res_q.p50_ns       <= '0;
        res_q.p95_ns       <= '0;
        res_q.p99_ns       <= '0;
      end else begin
        res_q.sample_count <= qcnt;
        res_q.time_total   <= tsum_q[item_q.probe_index];
        res_q.time_min     <= tmin_q[item_q.probe_index];
        res_q.time_max     <= tmax_q[item_q.probe_index];
        res_q.bytes_sum    <= bsum_q[item_q.probe_index];
        res_q.p50_ns       <= tmax_q[item_q.probe_index];
        res_q.p95_ns       <= tmax_q[item_q.probe_index];
        res_q.p99_ns       <= tmax_q[item_q.probe_index];
      end
      // cnt*P, compared against 100*cum during the walk
      rank_q[0] <= {7'd0, qcnt} * RankW'(50);
      rank_q[1] <= {7'd0, qcnt} * RankW'(95);
      rank_q[2] <= {7'd0, qcnt} * RankW'(99);
      cum_q     <= '0;
      walk_rd_q <= '0;
      walk_b_q  <= '0;
    end
    if (cmd_i.walk_rd) walk_rd_q <= walk_rd_q + 1'b1;
    if (cmd_i.walk_acc) begin
      cum_q          <= cum_next;
      walk_b_q       <= walk_b_q + 1'b1;
      res_q.p50_ns   <= p_next[0];
      res_q.p95_ns   <= p_next[1];
      res_q.p99_ns   <= p_next[2];
    end
  end

endmodule

// ===== src/lhp_checker.sv =====
// ----------------------------------------------------------------------------
// lhp_checker
// port level checks for the latency histogram block
// ----------------------------------------------------------------------------
module lhp_checker
  import lhp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // a result is held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result dropped under stall");

  // no input taken while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while result pending");

  // accepted item of a used kind makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.kind != KindNone |=> in_stall_o)
    else $error("block not busy after accept");

endmodule

bind latency_histogram_percentiles lhp_checker u_lhp_checker (.*);

// ===== test/tb_latency_histogram_percentiles.sv =====
// ----------------------------------------------------------------------------
// tb_latency_histogram_percentiles
// self-checking bench: records, queries and clears go into the block; an
// in-bench copy of the per-probe statistics and log2 histogram predicts every
// query result, which is checked field by field as it leaves the block
// ----------------------------------------------------------------------------
module tb_latency_histogram_percentiles;
  import lhp_pkg::*;

  localparam int unsigned WatchLimit = 5000;   // cycles with no item moving
  localparam int unsigned DrainWait  = 700;    // a clear walks all 512 buckets

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  latency_histogram_percentiles i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #10 clk_i = ~clk_i;

  // shadow of the per-probe statistics
  logic [CntW-1:0]  shd_count [Probes];
  logic [DataW-1:0] shd_time  [Probes];
  logic [DataW-1:0] shd_bytes [Probes];
  logic [DataW-1:0] shd_min   [Probes];
  logic [DataW-1:0] shd_max   [Probes];
  logic [CntW-1:0]  shd_hist  [Probes][Buckets];

  out_item_t pending_stats[$];   // query answers not yet seen
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  // long receiver hold-off requests, served by the stall process
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;

  function automatic int unsigned bucket_of(logic [DataW-1:0] v);
    int unsigned b;
    b = 0;
    for (int i = 1; i < DataW; i++) begin
      if (v[i]) b = i;
    end
    return b;
  endfunction

  function automatic logic [DataW-1:0] bound_of(int unsigned b);
    if (b >= Buckets - 1) return '1;
    return (64'd1 << (b + 1)) - 64'd1;
  endfunction

  task automatic wipe_probes();
    for (int p = 0; p < Probes; p++) begin
      shd_count[p] = '0;
      shd_time[p]  = '0;
      shd_bytes[p] = '0;
      shd_min[p]   = '0;
      shd_max[p]   = '0;
      for (int b = 0; b < Buckets; b++) shd_hist[p][b] = '0;
    end
  endtask

  // update the shadow with one accepted item, queue the answer of a query
  task automatic apply_item(in_item_t it);
    int unsigned p;
    int unsigned b;
    int unsigned t;
    logic [63:0] rank [3];
    logic [63:0] cum;
    logic [63:0] cnt;
    out_item_t ans;
    p = it.probe_index;
    case (it.kind)
      KindRecord: begin
        if (shd_count[p] == '0) begin
          shd_min[p] = it.elapsed_ns;
          shd_max[p] = it.elapsed_ns;
        end else begin
          if (it.elapsed_ns < shd_min[p]) shd_min[p] = it.elapsed_ns;
          if (it.elapsed_ns > shd_max[p]) shd_max[p] = it.elapsed_ns;
        end
        if (shd_count[p] != CntMax) shd_count[p] = shd_count[p] + 1'b1;
        shd_time[p]  = shd_time[p] + it.elapsed_ns;
        shd_bytes[p] = shd_bytes[p] + it.byte_count;
        b = bucket_of(it.elapsed_ns);
        if (shd_hist[p][b] != CntMax) shd_hist[p][b] = shd_hist[p][b] + 1'b1;
      end
      KindQuery: begin
        ans = '0;
        ans.probe_id = it.probe_index;
        if (shd_count[p] != '0) begin
          cnt = 64'(shd_count[p]);
          rank[0] = cnt * 50 / 100;
          rank[1] = cnt * 95 / 100;
          rank[2] = cnt * 99 / 100;
          ans.sample_count = shd_count[p];
          ans.time_total   = shd_time[p];
          ans.time_min     = shd_min[p];
          ans.time_max     = shd_max[p];
          ans.bytes_sum    = shd_bytes[p];
          ans.p50_ns       = shd_max[p];
          ans.p95_ns       = shd_max[p];
          ans.p99_ns       = shd_max[p];
          cum = '0;
          t = 0;
          for (b = 0; b < Buckets && t < 3; b++) begin
            cum = cum + 64'(shd_hist[p][b]);
            while (t < 3 && cum > rank[t]) begin
              if (t == 0) ans.p50_ns = bound_of(b);
              else if (t == 1) ans.p95_ns = bound_of(b);
              else ans.p99_ns = bound_of(b);
              t++;
            end
          end
        end
        pending_stats = {pending_stats, ans};
      end
      KindClear: wipe_probes();
      default: ;   // unused kind, dropped by the block
    endcase
  endtask

  // offer one item, wait for it to be taken, then maybe leave a gap
  task automatic send_item(in_item_t it);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    apply_item(it);
    gap = $urandom_range(0, 99);
    if (gap < 55) gap = 0;
    else if (gap < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic in_item_t make_item(logic [1:0] kind, int unsigned probe,
                                         logic [63:0] el, logic [63:0] by);
    in_item_t it;
    it.kind        = kind;
    it.probe_index = ProbeW'(probe);
    it.elapsed_ns  = el;
    it.byte_count  = by;
    return it;
  endfunction

  function automatic logic [63:0] rand_elapsed();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = 64'($urandom_range(0, 3));
      1: v = '1 >> $urandom_range(0, 63);
      default: v = v >> $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  // ------------------------------------------------------------------------
  // test tasks
  // ------------------------------------------------------------------------

  // queries on untouched probes, all fields but the probe id zero
  task automatic test_empty_probes();
    send_item(make_item(KindQuery, 0, '0, '0));
    send_item(make_item(KindQuery, Probes - 1, '1, '1));
  endtask

  // extremes of elapsed and bytes, wrapping sums, first and last bucket
  task automatic test_extremes();
    send_item(make_item(KindRecord, 0, 64'd0, '1));
    send_item(make_item(KindRecord, 0, 64'd1, '1));
    send_item(make_item(KindRecord, 0, 64'd2, 64'd5));
    send_item(make_item(KindRecord, 0, '1, 64'd0));
    send_item(make_item(KindQuery, 0, '0, '0));
    send_item(make_item(KindRecord, Probes - 1, '1, '1));
    send_item(make_item(KindRecord, Probes - 1, 64'h8000_0000_0000_0000, '1));
    send_item(make_item(KindRecord, Probes - 1, 64'h4000_0000_0000_0000, 64'd3));
    send_item(make_item(KindQuery, Probes - 1, '0, '0));
    // single sample probe, every percentile in one bucket
    send_item(make_item(KindRecord, 3, 64'd1000, 64'd64));
    send_item(make_item(KindQuery, 3, '0, '0));
  endtask

  // the unused kind is dropped, a clear empties every probe
  task automatic test_clear_and_unused();
    send_item(make_item(KindNone, 3, '1, '1));
    send_item(make_item(KindQuery, 3, '0, '0));
    send_item(make_item(KindClear, 0, '0, '0));
    send_item(make_item(KindQuery, 0, '0, '0));
    send_item(make_item(KindQuery, Probes - 1, '0, '0));
    send_item(make_item(KindRecord, 5, 64'd7, 64'd9));
    send_item(make_item(KindQuery, 5, '0, '0));
  endtask

  // receiver holds off while queries keep coming, the block backs up
  task automatic test_backpressure();
    hold_req++;
    for (int i = 0; i < 12; i++) begin
      send_item(make_item(KindRecord, i % Probes, rand_elapsed(), {$urandom, $urandom}));
      send_item(make_item(KindQuery, i % Probes, '0, '0));
    end
  endtask

  // mostly records with queries in between, rare clears and unused kinds
  task automatic test_random_traffic(int unsigned n);
    int unsigned r;
    logic [1:0] kind;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 199);
      if (r < 140) kind = KindRecord;
      else if (r < 193) kind = KindQuery;
      else if (r < 196) kind = KindClear;
      else kind = KindNone;
      send_item(make_item(kind, $urandom_range(0, Probes - 1), rand_elapsed(),
                          {$urandom, $urandom}));
    end
  endtask

  // ------------------------------------------------------------------------
  // receiver: random stalls, quiet stretches, and long hold-offs on request
  // ------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned free_left = 0;
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      stall_left = 300;
    end
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (free_left != 0) begin
      out_stall_i <= 1'b0;
      free_left--;
    end else begin
      out_stall_i <= 1'b0;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: stall_left = $urandom_range(1, 3);
        7: stall_left = $urandom_range(15, 60);
        8, 9: free_left = $urandom_range(20, 120);
        default: free_left = $urandom_range(0, 4);
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // result checker
  // ------------------------------------------------------------------------
  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected result for probe %0d", $realtime, out_item_o.probe_id);
        mismatches++;
      end else begin
        want = pending_stats.pop_front();
        check_field("probe_id", 64'(want.probe_id), 64'(out_item_o.probe_id));
        check_field("sample_count", 64'(want.sample_count), 64'(out_item_o.sample_count));
        check_field("time_total", want.time_total, out_item_o.time_total);
        check_field("time_min", want.time_min, out_item_o.time_min);
        check_field("time_max", want.time_max, out_item_o.time_max);
        check_field("bytes_sum", want.bytes_sum, out_item_o.bytes_sum);
        check_field("p50_ns", want.p50_ns, out_item_o.p50_ns);
        check_field("p95_ns", want.p95_ns, out_item_o.p95_ns);
        check_field("p99_ns", want.p99_ns, out_item_o.p99_ns);
      end
    end
  end

  // watchdog: too long with nothing moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------
  initial begin
    wipe_probes();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_probes();
    test_extremes();
    test_clear_and_unused();
    test_backpressure();
    test_random_traffic(1780);
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lhp_pkg.sv
src/lhp_ctrl.sv
src/lhp_dp.sv
src/latency_histogram_percentiles.sv
src/lhp_checker.sv
test/tb_latency_histogram_percentiles.sv
